@@ hdl/sfdi_pkg.sv @@
`timescale 1ns / 1ps

package sfdi_pkg;

	// Default sizes of the delay store and of one sample.
	localparam int DEF_STORE_DEPTH = 131072;
	localparam int DEF_SAMPLE_BITS = 24;

	// Fixed-point formats.
	localparam int FRAC_BITS = 24;
	localparam int GAIN_BITS = 16;
	localparam int SD_BITS   = 42;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 33;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_MIX       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FEEDBACK_GAIN = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_TARGET  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTH_COEFF  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STORE_LENGTH  = 3'd4;

	// Register widths and reset values.
	localparam logic [16:0] RST_WET_MIX       = 17'd32768;
	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd32768;
	localparam logic [32:0] RST_DELAY_TARGET  = 33'd1572864000;
	localparam logic [23:0] RST_SMOOTH_COEFF  = 24'd1678;
	localparam logic [17:0] RST_STORE_LENGTH  = 18'd96000;
	localparam logic [16:0] WET_ONE           = 17'd65536;

	// Smoothed delay after reset: the reset target moved to Q.24.
	localparam logic [SD_BITS-1:0] RST_SMOOTHED = {1'b0, RST_DELAY_TARGET, 8'd0};

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic clr;
		logic accept;
		logic sma;
		logic smb;
		logic smu;
		logic ad1;
		logic ad2;
		logic rd0;
		logic rd1;
		logic intp;
		logic int2;
		logic fbm;
		logic fba;
		logic mix;
	} sfdi_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} sfdi_sts_t;

endpackage

@@ hdl/stereo_feedback_delay_interp.sv @@
// Stereo feedback delay with a smoothed fractional delay and linear interpolation.
// Input stream (s_axis_*): one stereo sample pair per item, tdata holds
// left_in in the lowest bits and right_in above it, both signed Q1.23.
// Output stream (m_axis_*): one mixed pair per item, left_out then right_out.
// Configuration: cfg_we writes cfg_data into the register that cfg_index
// selects (0 wet_mix, 1 feedback_gain, 2 delay_target, 3 smoothing_coeff,
// 4 store_length); write only while no item is in flight.
// After reset the block clears the delay store, one entry per cycle, all
// STORE_DEPTH entries (131072 by default); s_axis_tready stays low meanwhile.
// A controller walks one item through smoothing, address arithmetic, two
// reads of the single store read port, interpolation and the mix; at the mix
// step the result goes to the output register, which drives m_axis_tvalid.
// A result sits in an output register; if the receiver stalls, the next item
// is still accepted and worked on, and the block waits at the final step
// until the output register is free.
`timescale 1ns / 1ps

module stereo_feedback_delay_interp import sfdi_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DW          = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [DW-1:0]             s_axis_tdata,   // left_in, right_in
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [DW-1:0]             m_axis_tdata,   // left_out, right_out
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	sfdi_cmd_t cmd;
	sfdi_sts_t sts;

	// Step sequencer.
	sfdi_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	// Store, arithmetic and output register.
	sfdi_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DW          (DW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

@@ hdl/sfdi_ctrl.sv @@
`timescale 1ns / 1ps

module sfdi_ctrl import sfdi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_axis_tvalid,
	output logic      s_axis_tready,
	input  sfdi_sts_t sts,
	output sfdi_cmd_t cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SMA   = 4'd2;
	localparam logic [3:0] S_SMB   = 4'd3;
	localparam logic [3:0] S_SMU   = 4'd4;
	localparam logic [3:0] S_AD1   = 4'd5;
	localparam logic [3:0] S_AD2   = 4'd6;
	localparam logic [3:0] S_RD0   = 4'd7;
	localparam logic [3:0] S_RD1   = 4'd8;
	localparam logic [3:0] S_INTP  = 4'd9;
	localparam logic [3:0] S_INT2  = 4'd10;
	localparam logic [3:0] S_FBM   = 4'd11;
	localparam logic [3:0] S_FBA   = 4'd12;
	localparam logic [3:0] S_MIX   = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Next state and the command for the current step.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					state_d    = S_SMA;
				end
			end
			S_SMA: begin
				cmd.sma = 1'b1;
				state_d = S_SMB;
			end
			S_SMB: begin
				cmd.smb = 1'b1;
				state_d = S_SMU;
			end
			S_SMU: begin
				cmd.smu = 1'b1;
				state_d = S_AD1;
			end
			S_AD1: begin
				cmd.ad1 = 1'b1;
				state_d = S_AD2;
			end
			S_AD2: begin
				cmd.ad2 = 1'b1;
				state_d = S_RD0;
			end
			S_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_INTP;
			end
			S_INTP: begin
				cmd.intp = 1'b1;
				state_d  = S_INT2;
			end
			S_INT2: begin
				cmd.int2 = 1'b1;
				state_d  = S_FBM;
			end
			S_FBM: begin
				cmd.fbm = 1'b1;
				state_d = S_FBA;
			end
			S_FBA: begin
				cmd.fba = 1'b1;
				state_d = S_MIX;
			end
			S_MIX: begin
				// Hold here until the output register can take the result.
				if (!sts.out_busy) begin
					cmd.mix = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SMA)
		else $error("accepted item did not start the smoothing step");

	a_mix_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |-> !sts.out_busy)
		else $error("result loaded while output register still held an item");

	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MIX && sts.out_busy) |=> state_q == S_MIX)
		else $error("left the mix step while the output was stalled");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.clr_last) |=> state_q == S_IDLE)
		else $error("clearing pass did not end at the last entry");

endmodule

@@ hdl/sfdi_datapath.sv @@
`timescale 1ns / 1ps

module sfdi_datapath import sfdi_pkg::*; #(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int DW          = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [DW-1:0]             s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [DW-1:0]             m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  sfdi_cmd_t                 cmd,
	output sfdi_sts_t                 sts
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int LW = AW + 1;
	localparam int CW = (LW > 18) ? LW : 18;
	localparam int QW = LW + FRAC_BITS;
	localparam int MW = (QW > SD_BITS) ? QW : SD_BITS;
	localparam int YW = FRAC_BITS + 1;
	localparam int PW = SB + 1 + YW;

	localparam logic signed [PW-1:0] HALF24 = {{(PW-FRAC_BITS){1'b0}}, 1'b1, 23'd0};
	localparam logic signed [PW:0]   HALF16 = {{(PW+1-GAIN_BITS){1'b0}}, 1'b1, 15'd0};
	localparam logic signed [PW:0]   SAT_HI = {{(PW-SB+2){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW:0]   SAT_LO = {{(PW-SB+2){1'b1}}, {(SB-1){1'b0}}};

	// Clamp a wide signed value to the sample range.
	function automatic logic signed [SB-1:0] sat_f(input logic signed [PW:0] v);
		logic signed [SB-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SB-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SB-1:0];
		end else begin
			r = v[SB-1:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic [16:0] wet_q;
	logic [15:0] gain_q;
	logic [32:0] tgt_q;
	logic [23:0] coef_q;
	logic [17:0] slen_q;

	// Block state.
	logic [AW-1:0]        wp_q;
	logic [SD_BITS-1:0]   sd_q;
	logic signed [SB-1:0] fb_q [2];
	logic [AW-1:0]        clr_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] out_q [2];

	// Working registers of one item.
	logic signed [SB-1:0] in_q [2];
	logic [SD_BITS-1:0]   diff_q;
	logic                 dn_q;
	logic [53:0]          smp_q;
	logic [53:0]          smh_q;
	logic [QW-1:0]        d_q;
	logic [QW-1:0]        rp_q;
	logic [2*SB-1:0]      rd_q;
	logic signed [SB-1:0] a_q [2];
	logic signed [PW-1:0] prod_q [2];
	logic signed [PW-1:0] acc_q [2];
	logic signed [SB-1:0] dl_q [2];

	// Delay store: both channels of one entry in one word.
	logic [2*SB-1:0] mem [STORE_DEPTH];

	// Effective store length and derived values.
	logic [CW-1:0]      len_ext;
	logic [LW-1:0]      len;
	logic [QW-1:0]      lenq;
	logic [16:0]        wet_eff;
	logic [16:0]        dry;
	logic [SD_BITS-1:0] target;
	logic [LW-1:0]      wp_next;

	always_comb begin
		len_ext = CW'(slen_q);
		if (len_ext == '0) begin
			len = LW'(1);
		end else if (len_ext > CW'(STORE_DEPTH)) begin
			len = LW'(STORE_DEPTH);
		end else begin
			len = len_ext[LW-1:0];
		end
	end

	assign lenq    = {len, {FRAC_BITS{1'b0}}};
	assign wet_eff = (wet_q > WET_ONE) ? WET_ONE : wet_q;
	assign dry     = WET_ONE - wet_eff;
	assign target  = {1'b0, tgt_q, 8'd0};
	assign wp_next = LW'(wp_q) + LW'(1);

	// Smoothing multiplier: the distance times one half of the coefficient.
	logic [11:0] sm_y;
	logic [53:0] sm_p;
	logic [54:0] step_sum;
	logic [SD_BITS-1:0] step;

	assign sm_y     = cmd.sma ? coef_q[23:12] : coef_q[11:0];
	assign sm_p     = diff_q * sm_y;
	assign step_sum = {1'b0, smh_q} + 55'(smp_q >> 12);
	assign step     = step_sum[SD_BITS+11:12];

	// Read point: clamp the delay, then step back from the write position.
	logic [MW-1:0] sd_ext;
	logic [MW-1:0] lenq_ext;
	logic [QW-1:0] wpq;
	logic [QW:0]   rp_wrap;
	logic [LW-1:0] x0f;
	logic [LW-1:0] x0l;
	logic [AW-1:0] x0a;
	logic [LW-1:0] x1f;
	logic [AW-1:0] x1a;
	logic [AW-1:0] raddr;

	assign sd_ext   = MW'(sd_q);
	assign lenq_ext = MW'(lenq);
	assign wpq      = QW'({wp_q, {FRAC_BITS{1'b0}}});
	assign rp_wrap  = (QW+1)'(wpq) + (QW+1)'(lenq) - (QW+1)'(d_q);
	assign x0f      = rp_q[QW-1:FRAC_BITS];
	assign x0l      = (x0f >= len) ? '0 : x0f;
	assign x0a      = x0l[AW-1:0];
	assign x1f      = LW'(x0a) + LW'(1);
	assign x1a      = (x1f >= len) ? '0 : x1f[AW-1:0];
	assign raddr    = cmd.rd1 ? x1a : x0a;

	// Channel multipliers, one per channel, operands chosen by the step.
	logic signed [YW-1:0] ch_y;
	logic signed [SB:0]   ch_x [2];
	logic signed [PW-1:0] ch_p [2];
	logic signed [SB-1:0] rd_ch [2];
	logic signed [SB-1:0] wr_ch [2];
	logic signed [PW-1:0] rnd24 [2];
	logic signed [PW-1:0] dl_sum [2];
	logic signed [SB-1:0] fb_new [2];
	logic signed [SB-1:0] mix_new [2];

	always_comb begin
		if (cmd.sma) begin
			ch_y = YW'(dry);
		end else if (cmd.intp) begin
			ch_y = {1'b0, rp_q[FRAC_BITS-1:0]};
		end else if (cmd.fbm) begin
			ch_y = YW'(gain_q);
		end else begin
			ch_y = YW'(wet_eff);
		end
		for (int c = 0; c < 2; c++) begin
			rd_ch[c] = rd_q[c*SB +: SB];
			if (cmd.sma) begin
				ch_x[c] = (SB+1)'(in_q[c]);
			end else if (cmd.intp) begin
				ch_x[c] = (SB+1)'(rd_ch[c]) - (SB+1)'(a_q[c]);
			end else begin
				ch_x[c] = (SB+1)'(dl_q[c]);
			end
			ch_p[c]    = ch_x[c] * ch_y;
			wr_ch[c]   = sat_f((PW+1)'(in_q[c]) + (PW+1)'(fb_q[c]));
			rnd24[c]   = (prod_q[c] + HALF24) >>> FRAC_BITS;
			dl_sum[c]  = PW'(a_q[c]) + rnd24[c];
			fb_new[c]  = sat_f(((PW+1)'(prod_q[c]) + HALF16) >>> GAIN_BITS);
			mix_new[c] = sat_f(((PW+1)'(acc_q[c]) + (PW+1)'(prod_q[c]) + HALF16)
				>>> GAIN_BITS);
		end
	end

	// Store port: clearing pass or the item's write, and one registered read.
	logic            mem_we;
	logic [AW-1:0]   waddr;
	logic [2*SB-1:0] wdata;

	assign mem_we = cmd.clr || cmd.sma;
	assign waddr  = cmd.clr ? clr_q : wp_q;
	assign wdata  = cmd.clr ? '0 : {wr_ch[1], wr_ch[0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q  <= RST_WET_MIX;
			gain_q <= RST_FEEDBACK_GAIN;
			tgt_q  <= RST_DELAY_TARGET;
			coef_q <= RST_SMOOTH_COEFF;
			slen_q <= RST_STORE_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WET_MIX:       wet_q  <= cfg_data[16:0];
				CFG_FEEDBACK_GAIN: gain_q <= cfg_data[15:0];
				CFG_DELAY_TARGET:  tgt_q  <= cfg_data[32:0];
				CFG_SMOOTH_COEFF:  coef_q <= cfg_data[23:0];
				CFG_STORE_LENGTH:  slen_q <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	// Block state: write position, smoothed delay, feedback, clear counter, output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			sd_q        <= RST_SMOOTHED;
			fb_q[0]     <= '0;
			fb_q[1]     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept && (LW'(wp_q) >= len)) begin
				wp_q <= '0;
			end
			if (cmd.smu) begin
				sd_q <= dn_q ? (sd_q - step) : (sd_q + step);
			end
			if (cmd.fba) begin
				fb_q <= fb_new;
			end
			if (cmd.mix) begin
				wp_q        <= (wp_next >= len) ? '0 : wp_next[AW-1:0];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q[0] <= s_axis_tdata[SB-1:0];
			in_q[1] <= s_axis_tdata[2*SB-1:SB];
			dn_q    <= (sd_q > target);
			diff_q  <= (sd_q > target) ? (sd_q - target) : (target - sd_q);
		end
		if (cmd.sma || cmd.smb) begin
			smp_q <= sm_p;
		end
		if (cmd.smb) begin
			smh_q <= smp_q;
			acc_q <= prod_q;
		end
		if (cmd.ad1) begin
			d_q <= (sd_ext >= lenq_ext) ? (lenq - QW'(1)) : QW'(sd_q);
		end
		if (cmd.ad2) begin
			rp_q <= (wpq >= d_q) ? (wpq - d_q) : rp_wrap[QW-1:0];
		end
		if (cmd.rd1) begin
			a_q <= rd_ch;
		end
		if (cmd.sma || cmd.intp || cmd.fbm || cmd.fba) begin
			prod_q <= ch_p;
		end
		if (cmd.int2) begin
			dl_q[0] <= dl_sum[0][SB-1:0];
			dl_q[1] <= dl_sum[1][SB-1:0];
		end
		if (cmd.mix) begin
			out_q <= mix_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'({out_q[1], out_q[0]});
	assign sts.out_busy  = out_valid_q && !m_axis_tready;
	assign sts.clr_last  = (clr_q == AW'(STORE_DEPTH - 1));

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |=> m_axis_tvalid)
		else $error("loaded result is not offered on the output");

	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sma |-> (LW'(wp_q) < len))
		else $error("store written beyond the length in use");

endmodule
